[hw/rtl/bce_pkg.sv]
// Shared constants and saturation helpers for the Bezier curve evaluator.
// Used by bce_mac and bezier_curve_evaluator; depends on nothing.
package bce_pkg;

  // default configuration
  localparam int MAX_POINTS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  // datapath widths
  localparam int ACC_W = 64;  // exact sum accumulator
  localparam int AOP_W = 36;  // first operand of the shared multiplier

  // command codes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_EVAL   = 2'd2;

  // clamp a wide signed value to a signed 32 bit word
  function automatic logic signed [31:0] sat_32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(64'sh0000_0000_7FFF_FFFF);
    lo = -hi - ACC_W'(1);
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // clamp a wide signed value to a signed 48 bit word
  function automatic logic signed [47:0] sat_48(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(64'sh0000_7FFF_FFFF_FFFF);
    lo = -hi - ACC_W'(1);
    if (v > hi) begin
      return 48'sh7FFF_FFFF_FFFF;
    end else if (v < lo) begin
      return 48'sh8000_0000_0000;
    end
    return v[47:0];
  endfunction

endpackage

[hw/rtl/bce_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module bce_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/bce_mac.sv]
// Shared signed multiply-add unit: sum = base + a * b.
// Uses bce_pkg for the operand and accumulator widths.
module bce_mac #(
  parameter int B_W = 22
) (
  input  logic signed [bce_pkg::AOP_W-1:0] a,
  input  logic signed [B_W-1:0]            b,
  input  logic signed [bce_pkg::ACC_W-1:0] base,
  output logic signed [bce_pkg::ACC_W-1:0] sum
);

  logic signed [bce_pkg::AOP_W+B_W-1:0] prod;

  // one product, added onto the selected base
  assign prod = a * b;
  assign sum  = base + bce_pkg::ACC_W'(prod);

endmodule

[hw/rtl/bezier_curve_evaluator.sv]
// Top level of the 2D Bezier curve evaluator: control-point store, sequencer.
// Depends on bce_pkg, bce_ram and bce_mac.
//
// Input channel (in_valid / in_stall) carries one command word: clear the
// point list, append a point (coord_x, coord_y), or evaluate at param_t.
// Clear and append give no result; an append to a full
// list is dropped. Evaluate gives one result word on the output channel
// (out_valid / out_stall): curve point, first and second derivative, count.
// One shared multiply-add unit builds Bernstein weights degree by degree
// (a decide step, then an A and a B pass per ring slot), then runs up to
// three weighted sums over the weight ring (read, x and y per point, a
// rotate step for each unused slot, then round and scale x and y). The
// result is out once the last sum is scaled; an empty list answers without
// any pass. in_stall drops in the same cycle that the result is registered.
// in_stall is high during evaluation. A finished result waits in the output
// register while out_stall is high; the next command is taken meanwhile,
// and a following evaluate holds its result until the register frees.
// Reset empties the list and drops any result; the point RAM is not cleared.
module bezier_curve_evaluator #(
  parameter int MAX_POINTS = bce_pkg::MAX_POINTS_DEF,
  parameter int FRAC_BITS  = bce_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic [16:0]        param_t,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic signed [47:0] slope_x,
  output logic signed [47:0] slope_y,
  output logic signed [47:0] bend_x,
  output logic signed [47:0] bend_y,
  output logic [4:0]         point_count
);

  localparam int ACC_W  = bce_pkg::ACC_W;
  localparam int AOP_W  = bce_pkg::AOP_W;
  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int WW     = FRAC_BITS + 2;   // weight width, unsigned
  localparam int CW     = FRAC_BITS + 6;   // coefficient width, signed
  localparam logic [WW-1:0] ONE = WW'(1) << FRAC_BITS;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_PASS_A, S_PASS_B, S_SUM_RD, S_SUM_X, S_SUM_Y,
    S_ROT, S_RND, S_FAC_X, S_FAC_Y, S_DONE
  } state_t;

  state_t                    state;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          deg;
  logic [1:0]                order;
  logic [IDX_W-1:0]          idx;
  logic [WW-1:0]             t_r;
  logic [WW-1:0]             s_r;
  logic [WW-1:0]             wq [MAX_POINTS];
  logic [WW-1:0]             wprev;
  logic [WW-1:0]             wd1;
  logic [WW-1:0]             wd2;
  logic signed [ACC_W-1:0]   accw;
  logic signed [ACC_W-1:0]   acc_x;
  logic signed [ACC_W-1:0]   acc_y;
  logic signed [AOP_W-1:0]   rnd_x;
  logic signed [AOP_W-1:0]   rnd_y;
  logic signed [CW-1:0]      factor;
  logic signed [31:0]        px;
  logic signed [31:0]        py;
  logic signed [47:0]        sx;
  logic signed [47:0]        sy;
  logic signed [47:0]        bx;
  logic signed [47:0]        by;

  logic                      in_acc;
  logic                      out_free;
  logic [WW-1:0]             t_sat;
  logic [CNT_W-1:0]          ord_gap;
  logic [CNT_W-1:0]          nm1;
  logic [2*CNT_W-1:0]        f2;
  logic                      ram_we;
  logic [63:0]               rdata;
  logic signed [31:0]        rd_x;
  logic signed [31:0]        rd_y;
  logic signed [CW-1:0]      w0s;
  logic signed [CW-1:0]      w1s;
  logic signed [CW-1:0]      w2s;
  logic signed [CW-1:0]      coef;
  logic signed [AOP_W-1:0]   mac_a;
  logic signed [CW-1:0]      mac_b;
  logic signed [ACC_W-1:0]   mac_base;
  logic signed [ACC_W-1:0]   mac_sum;
  logic [WW-1:0]             w_new;
  logic signed [ACC_W-1:0]   rsum_x;
  logic signed [ACC_W-1:0]   rsum_y;
  logic                      last_slot;
  logic                      more_pts;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // clamp t to one and work out the order and scale of the next sum
  assign t_sat   = (WW'(param_t) > ONE) ? ONE : WW'(param_t);
  assign ord_gap = count - CNT_W'(1) - deg;
  assign nm1     = count - CNT_W'(1);
  assign f2      = (2*CNT_W)'(nm1) * (2*CNT_W)'(count - CNT_W'(2));

  // point store
  assign ram_we = in_acc && (opcode == bce_pkg::OP_APPEND) &&
                  (count < CNT_W'(MAX_POINTS));

  bce_ram #(
    .WIDTH(64),
    .DEPTH(MAX_POINTS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count[IDX_W-1:0]),
    .wdata({coord_x, coord_y}),
    .raddr(idx),
    .rdata(rdata)
  );

  assign rd_x = rdata[63:32];
  assign rd_y = rdata[31:0];

  // weight-difference coefficient for the current point
  assign w0s = CW'(wq[0]);
  assign w1s = CW'(wd1);
  assign w2s = CW'(wd2);
  always_comb begin
    unique case (order)
      2'd0:    coef = w0s;
      2'd1:    coef = w1s - w0s;
      default: coef = w2s - (w1s <<< 1) + w0s;
    endcase
  end

  // select operands of the shared multiply-add unit
  always_comb begin
    mac_a    = '0;
    mac_b    = '0;
    mac_base = '0;
    unique case (state)
      S_PASS_A: begin
        mac_a    = AOP_W'(wq[0]);
        mac_b    = CW'(s_r);
        mac_base = HALF;
      end
      S_PASS_B: begin
        mac_a    = AOP_W'(wprev);
        mac_b    = CW'(t_r);
        mac_base = accw;
      end
      S_SUM_X: begin
        mac_a    = AOP_W'(rd_x);
        mac_b    = coef;
        mac_base = acc_x;
      end
      S_SUM_Y: begin
        mac_a    = AOP_W'(rd_y);
        mac_b    = coef;
        mac_base = acc_y;
      end
      S_FAC_X: begin
        mac_a = rnd_x;
        mac_b = factor;
      end
      S_FAC_Y: begin
        mac_a = rnd_y;
        mac_b = factor;
      end
      default: begin
        mac_a    = '0;
      end
    endcase
  end

  bce_mac #(
    .B_W(CW)
  ) u_mac (
    .a   (mac_a),
    .b   (mac_b),
    .base(mac_base),
    .sum (mac_sum)
  );

  assign w_new     = mac_sum[FRAC_BITS+WW-1:FRAC_BITS];
  assign rsum_x    = (acc_x + HALF) >>> FRAC_BITS;
  assign rsum_y    = (acc_y + HALF) >>> FRAC_BITS;
  assign last_slot = (idx == IDX_W'(MAX_POINTS - 1));
  assign more_pts  = (CNT_W'(idx) + CNT_W'(1)) < count;

  // sequencer, store count and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            priority case (opcode)
              bce_pkg::OP_CLEAR: count <= '0;
              bce_pkg::OP_APPEND: begin
                if (ram_we) begin
                  count <= count + CNT_W'(1);
                end
              end
              bce_pkg::OP_EVAL: begin
                t_r <= t_sat;
                s_r <= ONE - t_sat;
                px  <= '0;
                py  <= '0;
                sx  <= '0;
                sy  <= '0;
                bx  <= '0;
                by  <= '0;
                deg <= '0;
                for (int k = 0; k < MAX_POINTS; k++) begin
                  wq[k] <= (k == 0) ? ONE : '0;
                end
                state <= (count == '0) ? S_DONE : S_DECIDE;
              end
              default: ;
            endcase
          end
        end
        S_DECIDE: begin
          idx <= '0;
          if (ord_gap <= CNT_W'(2)) begin
            order <= ord_gap[1:0];
            acc_x <= '0;
            acc_y <= '0;
            wd1   <= '0;
            wd2   <= '0;
            priority if (ord_gap == CNT_W'(0)) begin
              factor <= CW'(1);
            end else if (ord_gap == CNT_W'(1)) begin
              factor <= CW'(nm1);
            end else begin
              factor <= CW'(f2);
            end
            state <= S_SUM_RD;
          end else begin
            wprev <= '0;
            state <= S_PASS_A;
          end
        end
        S_PASS_A: begin
          accw  <= mac_sum;
          state <= S_PASS_B;
        end
        S_PASS_B: begin
          // shift the weight ring, new weight enters at the tail
          for (int k = 0; k < MAX_POINTS - 1; k++) begin
            wq[k] <= wq[k+1];
          end
          wq[MAX_POINTS-1] <= w_new;
          wprev <= wq[0];
          if (last_slot) begin
            idx   <= '0;
            deg   <= deg + CNT_W'(1);
            state <= S_DECIDE;
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= S_PASS_A;
          end
        end
        S_SUM_RD: state <= S_SUM_X;
        S_SUM_X: begin
          acc_x <= mac_sum;
          state <= S_SUM_Y;
        end
        S_SUM_Y: begin
          acc_y <= mac_sum;
          for (int k = 0; k < MAX_POINTS - 1; k++) begin
            wq[k] <= wq[k+1];
          end
          wq[MAX_POINTS-1] <= wq[0];
          wd1 <= wq[0];
          wd2 <= wd1;
          if (last_slot) begin
            state <= S_RND;
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= more_pts ? S_SUM_RD : S_ROT;
          end
        end
        S_ROT: begin
          // realign the weight ring for the next pass
          for (int k = 0; k < MAX_POINTS - 1; k++) begin
            wq[k] <= wq[k+1];
          end
          wq[MAX_POINTS-1] <= wq[0];
          if (last_slot) begin
            state <= S_RND;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_RND: begin
          rnd_x <= AOP_W'(rsum_x);
          rnd_y <= AOP_W'(rsum_y);
          state <= S_FAC_X;
        end
        S_FAC_X: begin
          unique case (order)
            2'd0:    px <= bce_pkg::sat_32(mac_sum);
            2'd1:    sx <= bce_pkg::sat_48(mac_sum);
            default: bx <= bce_pkg::sat_48(mac_sum);
          endcase
          state <= S_FAC_Y;
        end
        S_FAC_Y: begin
          unique case (order)
            2'd0:    py <= bce_pkg::sat_32(mac_sum);
            2'd1:    sy <= bce_pkg::sat_48(mac_sum);
            default: by <= bce_pkg::sat_48(mac_sum);
          endcase
          idx <= '0;
          if (order == 2'd0) begin
            state <= S_DONE;
          end else begin
            wprev <= '0;
            state <= S_PASS_A;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (out_free) begin
            point_x     <= px;
            point_y     <= py;
            slope_x     <= sx;
            slope_y     <= sy;
            bend_x      <= bx;
            bend_y      <= by;
            point_count <= 5'(count);
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // the stored count never passes capacity
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_POINTS))
    else $error("point count above capacity");

  // an append to a full list leaves the count alone
  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    in_acc && (opcode == bce_pkg::OP_APPEND) && (count == CNT_W'(MAX_POINTS))
    |=> count == CNT_W'(MAX_POINTS))
    else $error("append to full list changed the count");

  // an accepted evaluate makes the block busy
  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    in_acc && (opcode == bce_pkg::OP_EVAL) |=> in_stall)
    else $error("evaluate accepted without going busy");

  // a new result carries the current count
  a_res_count: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> point_count == 5'(count))
    else $error("result count differs from stored count");

endmodule
